// File: design/dtr_pkg.sv
// Shared types, register indexes and the tap-select table of the divider timer.
// No dependencies; every other design file imports this package.
package dtr_pkg;

    localparam int CYC_W = 5;
    localparam int CNT_W = 8;
    localparam int DIV_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int BIT_IDX_W = $clog2(DIV_W);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_TIMER_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_SELECT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODULO_VALUE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_SPEED = 2'd3;

    // Sequencer taps; the edge is watched one bit above the tap.
    localparam logic [BIT_IDX_W-1:0] SEQ_WATCH_NORMAL = 4'd13;
    localparam logic [BIT_IDX_W-1:0] SEQ_WATCH_DOUBLE = 4'd14;

    typedef struct packed {
        logic             timer_enable;
        logic [1:0]       clock_select;
        logic [CNT_W-1:0] modulo_value;
        logic             double_speed;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0] counter_value;
        logic             overflow_irq;
        logic             sequencer_tick;
        logic [DIV_W-1:0] divider_value;
    } t_result;

    // Divider bit watched for the timer tap: one above bit 9, 3, 5 or 7.
    function automatic logic [BIT_IDX_W-1:0] timer_watch_bit(input logic [1:0] sel);
        logic [BIT_IDX_W-1:0] b;
        unique case (sel)
            2'd0:    b = 4'd10;
            2'd1:    b = 4'd4;
            2'd2:    b = 4'd6;
            default: b = 4'd8;
        endcase
        return b;
    endfunction

endpackage

// File: design/dtr_ifs.sv
// Valid/ready channel interfaces for the divider timer input and result words.
// Depends on dtr_pkg for the field widths.
interface dtr_in_if import dtr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CYC_W-1:0] cycles;

    modport source (output valid, output cycles, input ready);
    modport sink   (input valid, input cycles, output ready);
endinterface

interface dtr_out_if import dtr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] counter_value;
    logic             overflow_irq;
    logic             sequencer_tick;
    logic [DIV_W-1:0] divider_value;

    modport source (output valid, output counter_value, output overflow_irq,
                    output sequencer_tick, output divider_value, input ready);
    modport sink   (input valid, input counter_value, input overflow_irq,
                    input sequencer_tick, input divider_value, output ready);
endinterface

// File: design/dtr_step.sv
// Next-state logic of one step: reload countdown, divider advance, edge detection.
// Depends on dtr_pkg.
module dtr_step import dtr_pkg::*; #(
    parameter int RELOAD_DELAY = 4,
    parameter int RW_W = 3
) (
    input  logic [CYC_W-1:0] i_cycles,
    input  t_cfg             i_cfg,
    input  logic [DIV_W-1:0] i_divider,
    input  logic [CNT_W-1:0] i_counter,
    input  logic [RW_W-1:0]  i_reload_wait,
    output logic [DIV_W-1:0] o_divider,
    output logic [CNT_W-1:0] o_counter,
    output logic [RW_W-1:0]  o_reload_wait,
    output t_result          o_result
);

    logic [CNT_W-1:0]     cnt_mid;
    logic [RW_W-1:0]      rw_mid;
    logic                 irq;
    logic [DIV_W-1:0]     new_div;
    logic [BIT_IDX_W-1:0] tbit;
    logic [BIT_IDX_W-1:0] sbit;
    logic                 timer_edge;
    logic                 seq_edge;

    // A pending reload counts down first and fires when it runs out.
    always_comb begin
        cnt_mid = i_counter;
        rw_mid  = i_reload_wait;
        irq     = 1'b0;
        if (i_reload_wait != '0 && i_cycles != '0) begin
            if (i_cycles >= CYC_W'(i_reload_wait)) begin
                rw_mid  = '0;
                cnt_mid = i_cfg.modulo_value;
                irq     = 1'b1;
            end else begin
                rw_mid = i_reload_wait - RW_W'(i_cycles);
            end
        end
    end

    assign new_div    = i_divider + DIV_W'(i_cycles);
    assign tbit       = timer_watch_bit(i_cfg.clock_select);
    assign sbit       = i_cfg.double_speed ? SEQ_WATCH_DOUBLE : SEQ_WATCH_NORMAL;
    assign timer_edge = i_divider[tbit] ^ new_div[tbit];
    assign seq_edge   = i_divider[sbit] ^ new_div[sbit];

    always_comb begin
        o_counter     = cnt_mid;
        o_reload_wait = rw_mid;
        if (i_cfg.timer_enable && timer_edge) begin
            if (cnt_mid == '1) begin
                o_counter     = '0;
                o_reload_wait = RW_W'(RELOAD_DELAY);
            end else begin
                o_counter = cnt_mid + 1'b1;
            end
        end
    end

    assign o_divider = new_div;

    assign o_result.counter_value  = o_counter;
    assign o_result.overflow_irq   = irq;
    assign o_result.sequencer_tick = seq_edge;
    assign o_result.divider_value  = new_div;

endmodule

// File: design/divider_timer_with_reload.sv
// Top level of the divider timer with delayed reload.
// Depends on dtr_pkg, dtr_ifs (channel interfaces) and dtr_step.
//
// Each input word carries a cycle count; the block advances a free-running
// 16-bit divider by it, increments the 8-bit timer counter when the selected
// divider tap falls (if the timer is enabled), reloads the counter from the
// modulo register once the cycle counts of later words use up a reload wait
// of RELOAD_DELAY after an overflow, with an interrupt pulse, and flags a
// sequencer tick on a falling edge of bit 12 (bit 13 in double speed). Every
// input word yields exactly one result word. While the result side does not
// stall, one word is taken per clock cycle and the throughput is one word per
// cycle: the input word is registered in the input register, the step is
// computed combinationally from that register and the held state, and the
// result is written into the result register, which offers it. The result register
// is drained independently of the input side; the input stalls only when both
// the input register and the result register are full and the result is not
// being taken. Configuration registers are written through a plain write port
// and take effect for the next word processed; they should be changed only
// while no word is in flight.
module divider_timer_with_reload import dtr_pkg::*; #(
    parameter int RELOAD_DELAY = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    dtr_in_if.sink                i_in,
    dtr_out_if.source             o_out
);

    localparam int RW_W = $clog2(RELOAD_DELAY + 1);

    t_cfg             r_cfg;
    logic [DIV_W-1:0] r_div;
    logic [CNT_W-1:0] r_cnt;
    logic [RW_W-1:0]  r_rw;
    logic             r_s1_valid;
    logic [CYC_W-1:0] r_s1_cycles;
    logic             r_out_valid;
    t_result          r_out;

    logic [DIV_W-1:0] n_div;
    logic [CNT_W-1:0] n_cnt;
    logic [RW_W-1:0]  n_rw;
    t_result          n_out;
    logic             advance;

    // The working stage moves on whenever the result register is empty or
    // its word is being taken in this cycle.
    assign advance    = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || advance;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TIMER_ENABLE: r_cfg.timer_enable <= i_cfg_wdata[0];
                REG_CLOCK_SELECT: r_cfg.clock_select <= i_cfg_wdata[1:0];
                REG_MODULO_VALUE: r_cfg.modulo_value <= i_cfg_wdata;
                REG_DOUBLE_SPEED: r_cfg.double_speed <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_cycles <= i_in.cycles;
        end
    end

    dtr_step #(
        .RELOAD_DELAY (RELOAD_DELAY),
        .RW_W         (RW_W)
    ) u_step (
        .i_cycles      (r_s1_cycles),
        .i_cfg         (r_cfg),
        .i_divider     (r_div),
        .i_counter     (r_cnt),
        .i_reload_wait (r_rw),
        .o_divider     (n_div),
        .o_counter     (n_cnt),
        .o_reload_wait (n_rw),
        .o_result      (n_out)
    );

    // Timer state advances exactly once per word, as it enters the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div <= '0;
            r_cnt <= '0;
            r_rw  <= '0;
        end else if (r_s1_valid && advance) begin
            r_div <= n_div;
            r_cnt <= n_cnt;
            r_rw  <= n_rw;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && advance) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.counter_value  = r_out.counter_value;
    assign o_out.overflow_irq   = r_out.overflow_irq;
    assign o_out.sequencer_tick = r_out.sequencer_tick;
    assign o_out.divider_value  = r_out.divider_value;

endmodule

// File: design/dtr_checker.sv
// Port-level assertions for the divider timer, attached to the top level by bind.
// Depends on dtr_pkg and divider_timer_with_reload.
module dtr_checker import dtr_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [CNT_W-1:0] i_counter_value,
    input logic             i_overflow_irq,
    input logic             i_sequencer_tick,
    input logic [DIV_W-1:0] i_divider_value
);

    // After a reset cycle no result word is offered.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result word offered straight after reset");

    // With the result register empty the input side must never stall.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled although the result register is empty");

    // A sequencer tick needs a carry into bit 13 or 14 within one short step,
    // so the low divider bits have just wrapped.
    a_tick_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_sequencer_tick) |-> (i_divider_value[12:5] == '0))
        else $error("sequencer tick without a recent divider wrap");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_counter_value) && $stable(i_overflow_irq)
             && $stable(i_sequencer_tick) && $stable(i_divider_value)))
        else $error("stalled result word changed");

endmodule

bind divider_timer_with_reload dtr_checker u_dtr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_counter_value  (o_out.counter_value),
    .i_overflow_irq   (o_out.overflow_irq),
    .i_sequencer_tick (o_out.sequencer_tick),
    .i_divider_value  (o_out.divider_value)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for divider_timer_with_reload: predicts every result word.
// Depends on dtr_pkg and the dtr_in_if / dtr_out_if channel interfaces of the design.
module tb_top;
    import dtr_pkg::*;

    // Reload delay of the block; the instance keeps its default.
    localparam int RELOAD_DELAY = 4;
    // Pressure hold-off of the receiver, in cycles.
    localparam int HOLD_LEN = 64;

    typedef enum logic [1:0] {
        GAP_NONE,
        GAP_SENDER,
        GAP_RECEIVER,
        GAP_BOTH
    } t_gap_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    dtr_in_if  in_ch ();
    dtr_out_if res_ch ();

    divider_timer_with_reload dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (res_ch)
    );

    // Word stores: cycle counts still to be offered, and predicted results still to arrive.
    logic [CYC_W-1:0] cycles_q[$];
    t_result          expected_q[$];

    // Shadow of the configuration registers and of the timer state.
    t_cfg             shadow_cfg;
    logic [DIV_W-1:0] div_q;
    logic [CNT_W-1:0] cnt_q;
    logic [2:0]       reload_left;

    t_gap_mode gap_mode;
    bit        pressure_armed;
    bit        pressure_done;
    int        hold_left;
    bit        in_taken;

    int mismatches;
    int words_in;
    int words_out;
    int overflows;
    int reloads;
    int ticks;
    int settings_used;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Advances the predicted timer by one word, in the order the block works:
    // a pending reload counts down first, then the divider moves and both
    // watched bits are checked for a change across the step.
    task automatic advance_timer(input logic [CYC_W-1:0] cyc, output t_result r);
        logic [DIV_W-1:0] old_div;
        logic [DIV_W-1:0] new_div;
        int               tap;
        int               seq;
        r = '0;
        case (shadow_cfg.clock_select)
            2'd0:    tap = 10;
            2'd1:    tap = 4;
            2'd2:    tap = 6;
            default: tap = 8;
        endcase
        seq = shadow_cfg.double_speed ? int'(SEQ_WATCH_DOUBLE) : int'(SEQ_WATCH_NORMAL);

        // A zero-cycle word leaves a pending reload where it is.
        if (reload_left != 3'd0 && cyc != '0) begin
            if (cyc >= reload_left) begin
                reload_left = 3'd0;
                cnt_q = shadow_cfg.modulo_value;
                r.overflow_irq = 1'b1;
                reloads++;
            end else begin
                reload_left = reload_left - cyc[2:0];
            end
        end

        old_div = div_q;
        new_div = div_q + DIV_W'(cyc);
        div_q = new_div;

        // The counter still counts from zero while a reload is pending.
        if (shadow_cfg.timer_enable && old_div[tap] != new_div[tap]) begin
            if (cnt_q == 8'hFF) begin
                cnt_q = '0;
                reload_left = 3'(RELOAD_DELAY);
                overflows++;
            end else begin
                cnt_q = cnt_q + 8'd1;
            end
        end

        r.sequencer_tick = old_div[seq] != new_div[seq];
        if (r.sequencer_tick) begin
            ticks++;
        end
        r.counter_value = cnt_q;
        r.divider_value = div_q;
    endtask

    // Input side: offer the word at the head of the store, holding it until
    // it is taken. Changes happen at the falling edge.
    always @(negedge i_clk) begin : sender
        bit idle;
        idle = (gap_mode == GAP_SENDER && $urandom_range(99) < 61) ||
               (gap_mode == GAP_BOTH && $urandom_range(99) < 21);
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_taken) begin
            // Word still on offer: keep it there.
        end else if (cycles_q.size() != 0 && !idle) begin
            in_ch.valid  <= 1'b1;
            in_ch.cycles <= cycles_q[0];
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // Result side: random stalls, and once a long hold-off so that the block
    // fills up and pushes back on its input.
    always @(negedge i_clk) begin : receiver
        bit stall;
        stall = (gap_mode == GAP_RECEIVER && $urandom_range(99) < 61) ||
                (gap_mode == GAP_BOTH && $urandom_range(99) < 21);
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            res_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (pressure_armed && !pressure_done) begin
            res_ch.ready <= 1'b0;
            hold_left <= HOLD_LEN;
            pressure_done <= 1'b1;
        end else begin
            res_ch.ready <= !stall;
        end
    end

    // Both handshakes are sampled at the rising edge. The prediction is made
    // before the comparison, so a word taken in the same edge is already stored.
    always @(posedge i_clk) begin : monitor
        t_result want;
        t_result seen;
        if (!i_rst_n) begin
            in_taken = 1'b0;
        end else begin
            in_taken = in_ch.valid && in_ch.ready;
            if (in_taken) begin
                advance_timer(in_ch.cycles, want);
                expected_q.push_back(want);
                void'(cycles_q.pop_front());
                words_in++;
            end
            if (res_ch.valid && res_ch.ready) begin
                seen.counter_value  = res_ch.counter_value;
                seen.overflow_irq   = res_ch.overflow_irq;
                seen.sequencer_tick = res_ch.sequencer_tick;
                seen.divider_value  = res_ch.divider_value;
                words_out++;
                if (expected_q.size() == 0) begin
                    $error("result word with no prediction waiting: counter_value %0d",
                           seen.counter_value);
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    if (seen.counter_value !== want.counter_value) begin
                        $error("counter_value expected %0d got %0d",
                               want.counter_value, seen.counter_value);
                        mismatches++;
                    end
                    if (seen.overflow_irq !== want.overflow_irq) begin
                        $error("overflow_irq expected %0d got %0d",
                               want.overflow_irq, seen.overflow_irq);
                        mismatches++;
                    end
                    if (seen.sequencer_tick !== want.sequencer_tick) begin
                        $error("sequencer_tick expected %0d got %0d",
                               want.sequencer_tick, seen.sequencer_tick);
                        mismatches++;
                    end
                    if (seen.divider_value !== want.divider_value) begin
                        $error("divider_value expected %0d got %0d",
                               want.divider_value, seen.divider_value);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Picks a word's cycle count: mostly nominal steps, some longer steps and some zero steps.
    function automatic logic [CYC_W-1:0] pick_cycles();
        int r;
        r = $urandom_range(99);
        if (r < 4) begin
            return '0;
        end else if (r < 16) begin
            return CYC_W'($urandom_range(31, 17));
        end
        return CYC_W'($urandom_range(16, 1));
    endfunction

    // Waits until every word has been offered and every result has come back,
    // then lets the block settle.
    task automatic drain();
        while (cycles_q.size() != 0 || expected_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_TIMER_ENABLE: shadow_cfg.timer_enable = val[0];
            REG_CLOCK_SELECT: shadow_cfg.clock_select = val[1:0];
            REG_MODULO_VALUE: shadow_cfg.modulo_value = val;
            default:          shadow_cfg.double_speed = val[0];
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input bit en, input logic [1:0] sel,
                                 input logic [7:0] modulo, input bit dbl);
        write_reg(REG_TIMER_ENABLE, CFG_DATA_W'(en));
        write_reg(REG_CLOCK_SELECT, CFG_DATA_W'(sel));
        write_reg(REG_MODULO_VALUE, modulo);
        write_reg(REG_DOUBLE_SPEED, CFG_DATA_W'(dbl));
        settings_used++;
    endtask

    // Feeds words one at a time until an overflow has just armed the reload.
    // With near_wrap set, it also waits for the low four divider bits to read
    // 13 to 15, just short of a timer tap change, so that words with a cycle count
    // of one make the counter move while the reload is still pending.
    task automatic feed_until_armed(input bit near_wrap);
        int tries;
        tries = 0;
        do begin
            cycles_q.push_back(pick_cycles());
            drain();
            tries++;
        end while (!(reload_left == 3'(RELOAD_DELAY) &&
                     (!near_wrap || div_q[3:0] >= 4'd13)) && tries < 800);
    endtask

    task automatic random_phase(input bit en, input logic [1:0] sel,
                                input logic [7:0] modulo, input bit dbl,
                                input t_gap_mode mode, input bit squeeze,
                                input int count);
        apply_setting(en, sel, modulo, dbl);
        gap_mode = mode;
        pressure_armed = squeeze;
        for (int k = 0; k < count; k++) begin
            cycles_q.push_back(pick_cycles());
        end
        drain();
    endtask

    initial begin
        in_ch.valid    = 1'b0;
        in_ch.cycles   = '0;
        res_ch.ready   = 1'b0;
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_wdata      = '0;
        shadow_cfg     = '0;
        div_q          = '0;
        cnt_q          = '0;
        reload_left    = '0;
        gap_mode       = GAP_NONE;
        pressure_armed = 1'b0;
        pressure_done  = 1'b0;
        hold_left      = 0;
        in_taken       = 1'b0;
        mismatches     = 0;
        words_in       = 0;
        words_out      = 0;
        overflows      = 0;
        reloads        = 0;
        ticks          = 0;
        settings_used  = 0;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed words on the fastest tap: zero, the largest count, exact
        // multiples of the tap period and counts just above 16.
        apply_setting(1'b1, 2'd1, 8'hFF, 1'b0);
        cycles_q = '{5'd0, 5'd31, 5'd16, 5'd1, 5'd17, 5'd0, 5'd15, 5'd8, 5'd4, 5'd2,
                     5'd30, 5'd16};
        drain();

        // Timer disabled: the divider and the sequencer keep running.
        apply_setting(1'b0, 2'd3, 8'h00, 1'b1);
        cycles_q = '{5'd16, 5'd31, 5'd0, 5'd31, 5'd31};
        drain();

        // Run the counter up to its first overflow, then disable the timer
        // while the reload is pending: the reload and interrupt must still come.
        apply_setting(1'b1, 2'd1, 8'hFF, 1'b0);
        feed_until_armed(1'b0);
        write_reg(REG_TIMER_ENABLE, 8'd0);
        cycles_q = '{5'd1, 5'd0, 5'd1, 5'd1, 5'd1, 5'd1};
        drain();

        // With the modulo at its top every tap change overflows again; catch
        // one close to a tap change so the counter moves during the wait.
        write_reg(REG_TIMER_ENABLE, 8'd1);
        feed_until_armed(1'b1);
        cycles_q = '{5'd1, 5'd1, 5'd1, 5'd1, 5'd1};
        drain();

        // Random phases over several settings, with the modulo at both ends.
        random_phase(1'b1, 2'd1, 8'hFF, 1'b0, GAP_NONE,     1'b0, 190);
        random_phase(1'b1, 2'd2, 8'h80, 1'b1, GAP_SENDER,   1'b0, 190);
        random_phase(1'b1, 2'd1, 8'h00, 1'b0, GAP_NONE,     1'b1, 190);
        random_phase(1'b0, 2'd0, 8'hC8, 1'b1, GAP_BOTH,     1'b0, 170);
        random_phase(1'b1, 2'd0, 8'hFF, 1'b1, GAP_RECEIVER, 1'b0, 170);
        random_phase(1'b1, 2'd1, 8'hFE, 1'b0, GAP_SENDER,   1'b0, 190);
        random_phase(1'b1, 2'd3, 8'hF0, 1'b1, GAP_BOTH,     1'b0, 190);
        random_phase(1'b1, 2'd1, 8'hF8, 1'b0, GAP_RECEIVER, 1'b0, 190);

        // Anything still waiting here is a lost result.
        for (int k = 0; k < 2000 && expected_q.size() != 0; k++) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
        if (expected_q.size() != 0) begin
            $error("%0d predicted result words never arrived", expected_q.size());
            mismatches++;
        end

        $display("Run covered %0d words in and %0d out over %0d register settings.",
                 words_in, words_out, settings_used);
        $display("Seen %0d counter overflows, %0d reload interrupts, %0d sequencer ticks.",
                 overflows, reloads, ticks);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
design/dtr_pkg.sv
design/dtr_ifs.sv
design/dtr_step.sv
design/divider_timer_with_reload.sv
design/dtr_checker.sv
tb/tb_top.sv
